[hw/rtl/prgvk_pkg.sv]
// Shared types, constants and helpers for the point range gate and voxel key block.
// Depends on nothing; every other file in hw/rtl imports it.
package prgvk_pkg;

    localparam int COORD_BITS_DEFAULT = 20;

    localparam int RES_W         = 16;
    localparam int RANGE_W       = 19;
    localparam int ROW_W         = 48;
    localparam int TRANS_W       = 60;
    localparam int TRANS_FIELD_W = 20;
    localparam int COEF_W        = 16;
    localparam int FRAC_SHIFT    = 15;
    localparam int CFG_DATA_W    = 60;
    localparam int CFG_IDX_W     = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESOLUTION  = 3'd0,
        REG_MAX_RANGE   = 3'd1,
        REG_ROT_ROW_X   = 3'd2,
        REG_ROT_ROW_Y   = 3'd3,
        REG_ROT_ROW_Z   = 3'd4,
        REG_TRANSLATION = 3'd5
    } cfg_index_t;

    localparam logic [RES_W-1:0]   RES_RESET   = 16'd150;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 19'd5000;
    localparam logic [ROW_W-1:0]   ROW_X_RESET = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]   ROW_Y_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]   ROW_Z_RESET = 48'h4000_0000_0000;
    localparam logic [TRANS_W-1:0] TRANS_RESET = '0;

    // Configuration as seen by the datapath modules.
    typedef struct packed {
        logic [RES_W-1:0]   res;
        logic [RANGE_W-1:0] lim;
        logic [ROW_W-1:0]   row_x;
        logic [ROW_W-1:0]   row_y;
        logic [ROW_W-1:0]   row_z;
        logic [TRANS_W-1:0] trans;
    } cfg_t;

    // One signed Q1.14 coefficient out of a packed matrix row.
    function automatic logic signed [COEF_W-1:0] row_coef(input logic [ROW_W-1:0] row,
                                                          input int col);
        row_coef = $signed(row[COEF_W*col +: COEF_W]);
    endfunction

    // One signed millimetre translation component.
    function automatic logic signed [TRANS_FIELD_W-1:0] trans_comp(
        input logic [TRANS_W-1:0] t, input int axis);
        trans_comp = $signed(t[TRANS_FIELD_W*axis +: TRANS_FIELD_W]);
    endfunction

endpackage

[hw/rtl/prgvk_floor_div.sv]
// Pipelined signed floor divider by a positive 16-bit divisor, one quotient bit per stage.
// Depends on prgvk_pkg.
module prgvk_floor_div #(
    parameter int NW = 20
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [NW-1:0]         n,
    input  logic [prgvk_pkg::RES_W-1:0]  d,
    output logic signed [NW-1:0]         q
);
    import prgvk_pkg::*;

    localparam int MW = NW - 1;

    logic             neg_reg [0:MW];
    logic [MW-1:0]    qm_reg  [0:MW];
    logic [RES_W-1:0] rem_reg [0:MW];

    // A negative dividend is folded to ~n, so floor(n/d) = ~floor(~n/d).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= n[NW-1];
            qm_reg[0]  <= n[NW-1] ? ~n[MW-1:0] : n[MW-1:0];
            rem_reg[0] <= '0;
        end
    end

    // Restoring steps: the dividend shifts out at the top, quotient bits in at the bottom.
    for (genvar i = 1; i <= MW; i++)
    begin : g_step
        logic [RES_W:0] rs;
        logic           ge;

        always_comb
        begin
            rs = {rem_reg[i-1], qm_reg[i-1][MW-1]};
            ge = (rs >= {1'b0, d});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i] <= neg_reg[i-1];
                qm_reg[i]  <= {qm_reg[i-1][MW-2:0], ge};
                rem_reg[i] <= ge ? RES_W'(rs - {1'b0, d}) : rs[RES_W-1:0];
            end
        end
    end

    assign q = neg_reg[MW] ? ~{1'b0, qm_reg[MW]} : {1'b0, qm_reg[MW]};

endmodule

[hw/rtl/prgvk_range_gate.sv]
// Two-stage range gate: squared distance against the squared range limit.
// Depends on prgvk_pkg.
module prgvk_range_gate #(
    parameter int CB = prgvk_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [CB-1:0]          p_in  [3],
    input  logic [prgvk_pkg::RANGE_W-1:0] lim,
    output logic signed [CB-1:0]          p_out [3],
    output logic                          keep
);
    import prgvk_pkg::*;

    localparam int SQW  = 2 * CB - 1;
    localparam int CMPW = (2 * CB + 1 > 2 * RANGE_W) ? 2 * CB + 1 : 2 * RANGE_W;

    logic [SQW-1:0]       sq_reg   [3];
    logic signed [CB-1:0] pa_reg   [3];
    logic [2*RANGE_W-1:0] lim2_reg;
    logic signed [CB-1:0] pb_reg   [3];
    logic                 keep_reg;
    logic [CMPW-1:0]      dist2;

    // First stage: the three squares and the squared limit.
    for (genvar a = 0; a < 3; a++)
    begin : g_sq
        logic signed [2*CB-1:0] prod;
        assign prod = p_in[a] * p_in[a];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[a] <= prod[SQW-1:0];
                pa_reg[a] <= p_in[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lim2_reg <= lim * lim;
        end
    end

    // Second stage: sum and compare; a point exactly at the limit is kept.
    assign dist2 = CMPW'(sq_reg[0]) + CMPW'(sq_reg[1]) + CMPW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            keep_reg <= (dist2 <= CMPW'(lim2_reg));
            pb_reg   <= pa_reg;
        end
    end

    assign p_out = pb_reg;
    assign keep  = keep_reg;

endmodule

[hw/rtl/prgvk_rotate.sv]
// Three-stage voxel centre, rotation and translation, exact in 2^-15 mm units.
// Depends on prgvk_pkg.
module prgvk_rotate #(
    parameter int CB = prgvk_pkg::COORD_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [CB-1:0]        k   [3],
    input  logic [prgvk_pkg::RES_W-1:0] res,
    input  prgvk_pkg::cfg_t             cfg,
    output logic signed [CB+4:0]        pos [3]
);
    import prgvk_pkg::*;

    localparam int CW = CB + 2;
    localparam int PW = COEF_W + CW;
    localparam int AW = CB + 20;

    logic signed [CW-1:0] c_reg    [3];
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [CB+4:0] pos_reg  [3];
    logic [ROW_W-1:0]     rows     [3];

    assign rows[0] = cfg.row_x;
    assign rows[1] = cfg.row_y;
    assign rows[2] = cfg.row_z;

    // Voxel centre in half-millimetres: (2k+1) * res.
    for (genvar a = 0; a < 3; a++)
    begin : g_centre
        logic signed [CB+17:0] cprod;
        assign cprod = $signed({k[a], 1'b1}) * $signed({1'b0, res});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg[a] <= cprod[CW-1:0];
            end
        end
    end

    // Nine coefficient products.
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[r][j] <= row_coef(rows[r], j) * c_reg[j];
                end
            end
        end
    end

    // Row sum plus translation, then the exact floor division by 2^15.
    for (genvar r = 0; r < 3; r++)
    begin : g_sum
        logic signed [AW-1:0] tt;
        logic signed [AW-1:0] acc;

        always_comb
        begin
            tt  = AW'(trans_comp(cfg.trans, r)) <<< FRAC_SHIFT;
            acc = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]) + AW'(prod_reg[r][2]) + tt;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pos_reg[r] <= acc[AW-1:FRAC_SHIFT];
            end
        end
    end

    assign pos = pos_reg;

endmodule

[hw/rtl/point_range_gate_voxel_key.sv]
// Top level of the point range gate and voxel key block: configuration, valid line, output.
// Depends on prgvk_pkg, prgvk_range_gate, prgvk_floor_div and prgvk_rotate.

// Takes one lidar point per cycle, except while the pipeline is halted, and, if it lies
// within the range limit, returns the map-frame voxel key one result per kept point, in
// order. The pipeline is an input register, two range-gate stages, COORD_BITS stages of
// the first bit-per-stage divider, three rotation stages, COORD_BITS + 5 stages of the
// second divider and the output register. The whole pipeline advances together and halts
// only while the output holds a result that has not been taken. Configuration is
// read directly by every stage, so it must be written only while the block is empty.
module point_range_gate_voxel_key #(
    parameter int COORD_BITS = prgvk_pkg::COORD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [prgvk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prgvk_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       x_mm,
    input  logic signed [COORD_BITS-1:0]       y_mm,
    input  logic signed [COORD_BITS-1:0]       z_mm,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [COORD_BITS+1:0]       key_x,
    output logic signed [COORD_BITS+1:0]       key_y,
    output logic signed [COORD_BITS+1:0]       key_z
);
    import prgvk_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int KB     = CB + 2;
    localparam int NW2    = CB + 5;
    localparam int GATE_S = 2;
    localparam int LAST   = 5 + CB + NW2;

    cfg_t                  cfg_reg;
    logic [RES_W-1:0]      res_eff;
    logic                  en;
    logic                  vld_reg [0:LAST];
    logic                  out_valid_reg;
    logic signed [CB-1:0]  p_in_reg [3];
    logic signed [CB-1:0]  p_gated  [3];
    logic                  keep;
    logic signed [CB-1:0]  k        [3];
    logic signed [NW2-1:0] pos      [3];
    logic signed [NW2-1:0] q2       [3];
    logic signed [KB-1:0]  key_reg  [3];

    // Configuration registers; out-of-range indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.res   <= RES_RESET;
            cfg_reg.lim   <= RANGE_RESET;
            cfg_reg.row_x <= ROW_X_RESET;
            cfg_reg.row_y <= ROW_Y_RESET;
            cfg_reg.row_z <= ROW_Z_RESET;
            cfg_reg.trans <= TRANS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_RESOLUTION:  cfg_reg.res   <= cfg_data[RES_W-1:0];
                REG_MAX_RANGE:   cfg_reg.lim   <= cfg_data[RANGE_W-1:0];
                REG_ROT_ROW_X:   cfg_reg.row_x <= cfg_data[ROW_W-1:0];
                REG_ROT_ROW_Y:   cfg_reg.row_y <= cfg_data[ROW_W-1:0];
                REG_ROT_ROW_Z:   cfg_reg.row_z <= cfg_data[ROW_W-1:0];
                REG_TRANSLATION: cfg_reg.trans <= cfg_data[TRANS_W-1:0];
                default:         ;
            endcase
        end
    end

    // A zero resolution behaves as one.
    assign res_eff = (cfg_reg.res == '0) ? RES_W'(1) : cfg_reg.res;

    // The pipeline moves whenever the output register is empty or being emptied.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Input register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_in_reg[0] <= x_mm;
            p_in_reg[1] <= y_mm;
            p_in_reg[2] <= z_mm;
        end
    end

    // Valid line alongside the datapath; dropped points turn into bubbles after the gate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LAST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= LAST; s++)
            begin
                vld_reg[s] <= (s == GATE_S + 1) ? (vld_reg[s-1] && keep) : vld_reg[s-1];
            end
            out_valid_reg <= vld_reg[LAST];
        end
    end

    prgvk_range_gate #(.CB(CB)) u_gate (
        .clk   (clk),
        .en    (en),
        .p_in  (p_in_reg),
        .lim   (cfg_reg.lim),
        .p_out (p_gated),
        .keep  (keep)
    );

    // Sensor voxel index per axis.
    for (genvar a = 0; a < 3; a++)
    begin : g_div1
        prgvk_floor_div #(.NW(CB)) u_div (
            .clk (clk),
            .en  (en),
            .n   (p_gated[a]),
            .d   (res_eff),
            .q   (k[a])
        );
    end

    prgvk_rotate #(.CB(CB)) u_rot (
        .clk (clk),
        .en  (en),
        .k   (k),
        .res (res_eff),
        .cfg (cfg_reg),
        .pos (pos)
    );

    // Map voxel key per axis, saturated into the key range.
    for (genvar a = 0; a < 3; a++)
    begin : g_div2
        logic same_top;

        prgvk_floor_div #(.NW(NW2)) u_div (
            .clk (clk),
            .en  (en),
            .n   (pos[a]),
            .d   (res_eff),
            .q   (q2[a])
        );

        assign same_top = (&q2[a][NW2-1:KB-1]) || !(|q2[a][NW2-1:KB-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (same_top)
                begin
                    key_reg[a] <= q2[a][KB-1:0];
                end
                else
                begin
                    key_reg[a] <= q2[a][NW2-1] ? {1'b1, {(KB-1){1'b0}}}
                                               : {1'b0, {(KB-1){1'b1}}};
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign key_x     = key_reg[0];
    assign key_y     = key_reg[1];
    assign key_z     = key_reg[2];

endmodule
